>>> hdl/frame_timestamp_regenerator_core_assert.svh
// Assertion macros shared by the frame timestamp regenerator RTL.
`ifndef FRAME_TIMESTAMP_REGENERATOR_CORE_ASSERT_SVH
`define FRAME_TIMESTAMP_REGENERATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FTR_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) prop) else $error(msg);
`define FTR_ASSERT_NEVER(lbl, cond, msg) `FTR_ASSERT(lbl, !(cond), msg)
`else
`define FTR_ASSERT(lbl, prop, msg)
`define FTR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/ftr_pkg.sv
// Types and constants shared by the frame timestamp regenerator modules.
package ftr_pkg;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DIV_W = (CNT_W > 2) ? CNT_W : 2;
  localparam int unsigned TIME_W = 62;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned CFG_W = 40;
  localparam int unsigned FC_W = 32;
  localparam int unsigned PROD_W = 64;
  // Width of the frame-time offset; frame 2^32 at the half rate still fits.
  localparam int unsigned FT_W = 52;

  // Whole part of one frame period in 100 ns units; the thirds are added by phase.
  localparam logic [FT_W-1:0] FT_STEP_FULL = 52'd333666;
  localparam logic [FT_W-1:0] FT_STEP_HALF = 52'd667333;

  localparam logic [CFG_W-1:0] MAX_GAP_RST = 40'd30000000;
  localparam logic [CFG_W-1:0] MAX_JITTER_RST = 40'd2500000;

  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_HALF = 2'd1;
  localparam logic [1:0] REG_MAX_GAP = 2'd2;
  localparam logic [1:0] REG_MAX_JITTER = 2'd3;

  typedef enum logic [1:0] {
    KIND_TS_FIXED,
    KIND_TS_INTERP,
    KIND_FRAME
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [TIME_W-1:0] sample_time;
    logic [TAG_W-1:0]  frame_tag;
  } cmd_t;

  typedef struct packed {
    logic             interp;
    logic             half;
    logic [CFG_W-1:0] max_gap;
    logic [CFG_W-1:0] max_jitter;
    logic             clear;
  } cfg_t;
endpackage

>>> hdl/ftr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ftr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/ftr_div.sv
// Radix-2 restoring divider: 64-bit dividend by a narrow divisor.
module ftr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ftr_pkg::PROD_W-1:0] dividend_i,
  input  logic [ftr_pkg::DIV_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [ftr_pkg::PROD_W-1:0] quot_o
);
  import ftr_pkg::*;

  logic                       busy_q, done_q;
  logic [$clog2(PROD_W)-1:0]  cnt_q;
  logic [PROD_W-1:0]          dvd_q;
  logic [DIV_W:0]             rem_q;
  logic [DIV_W-1:0]           dsr_q;
  logic [DIV_W:0]             trial;
  logic                       qbit;

  assign trial = {rem_q[DIV_W-1:0], dvd_q[PROD_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= qbit ? (trial - {1'b0, dsr_q}) : trial;
        dvd_q <= {dvd_q[PROD_W-2:0], qbit};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;
endmodule

>>> hdl/ftr_front.sv
// Front end: configuration registers, input classification and command queue.
module ftr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [79:0]                s_axis_tdata_i,
  input  logic                       s_axis_tuser_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ftr_pkg::CFG_W-1:0]  cfg_wdata_i,
  output ftr_pkg::cfg_t              cfg_o,
  output logic                       cmd_valid_o,
  output ftr_pkg::cmd_t              cmd_o,
  input  logic                       cmd_pop_i
);
  import ftr_pkg::*;

  logic             interp_q, half_q, clear_q;
  logic [CFG_W-1:0] gap_q, jit_q;
  cmd_t             fifo_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;
  cmd_t             entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 1'b0;
      half_q   <= 1'b0;
      gap_q    <= MAX_GAP_RST;
      jit_q    <= MAX_JITTER_RST;
      clear_q  <= 1'b0;
    end else begin
      clear_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INTERP: begin
            clear_q  <= (cfg_wdata_i[0] != interp_q);
            interp_q <= cfg_wdata_i[0];
          end
          REG_HALF: begin
            clear_q <= (cfg_wdata_i[0] != half_q);
            half_q  <= cfg_wdata_i[0];
          end
          REG_MAX_GAP:    gap_q <= cfg_wdata_i;
          REG_MAX_JITTER: jit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    entry.kind = s_axis_tuser_i ? KIND_FRAME : (interp_q ? KIND_TS_INTERP : KIND_TS_FIXED);
    entry.sample_time = s_axis_tdata_i[TIME_W-1:0];
    entry.frame_tag = s_axis_tdata_i[TIME_W+TAG_W-1:TIME_W];
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = cmd_pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        fifo_q[wr_q] <= entry;
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rd_q];

  always_comb begin
    cfg_o.interp     = interp_q;
    cfg_o.half       = half_q;
    cfg_o.max_gap    = gap_q;
    cfg_o.max_jitter = jit_q;
    cfg_o.clear      = clear_q;
  end
endmodule

>>> hdl/ftr_back.sv
// Back end: timing state, pending-frame queue, divider sequencing, result register.
`include "frame_timestamp_regenerator_core_assert.svh"
module ftr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ftr_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  ftr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [143:0]  m_axis_tdata_o,
  output logic          m_axis_tlast_o
);
  import ftr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHK, S_MUL, S_DIVS, S_DIVW, S_RD, S_RDW, S_EMIT
  } state_e;

  state_e            state_q;
  kind_e             kind_q;
  logic [TIME_W-1:0] t_q, base_q, st_q;
  logic [TAG_W-1:0]  tag_q;
  logic              bv_q, flush_q;
  logic [FC_W-1:0]   fc_q;
  logic [FT_W-1:0]   ft_q;
  logic [1:0]        ph_q;
  logic [TIME_W:0]   nom_q;
  logic [CNT_W-1:0]  pcnt_q, idx_q, cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic              ov_q, ol_q;
  logic [143:0]      od_q;
  logic [TAG_W-1:0]  em_tag_q;
  logic              em_has_q, em_last_q;
  logic [TIME_W-1:0] em_st_q, em_en_q;

  logic [TIME_W-1:0]      dur;
  logic [CNT_W-1:0]       idx1;
  logic [64+CNT_W-1:0]    prod_i;
  logic [FT_W-1:0]        ft_step;
  logic [PROD_W:0]        sum;
  logic [TIME_W:0]        t_ext, diff;
  logic                   div_start, div_busy, div_done;
  logic [PROD_W-1:0]      quot;
  logic                   ram_we, ram_re;
  logic [TAG_W-1:0]       ram_rdata;
  logic                   slot_free, is_flush;

  assign dur    = t_q - base_q;
  assign idx1   = idx_q + CNT_W'(1);
  assign prod_i = (64+CNT_W)'(dur) * (64+CNT_W)'(idx1);
  assign sum    = (PROD_W+1)'(base_q) + (PROD_W+1)'(quot);
  assign t_ext  = (TIME_W+1)'(t_q);
  assign diff   = (nom_q >= t_ext) ? (nom_q - t_ext) : (t_ext - nom_q);
  assign slot_free = !ov_q || m_axis_tready_i;
  assign is_flush = !bv_q || (base_q >= t_q) ||
                    ((TIME_W+1)'(base_q) + (TIME_W+1)'(cfg_i.max_gap) < (TIME_W+1)'(t_q));

  // The period in 100 ns units is a whole part plus one third or two thirds, so the
  // offset of the next frame grows by the whole part plus one on some phases of three.
  always_comb begin
    if (cfg_i.half) begin
      ft_step = FT_STEP_HALF + FT_W'(ph_q == 2'd2);
    end else begin
      ft_step = FT_STEP_FULL + FT_W'(ph_q != 2'd0);
    end
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign div_start = (state_q == S_DIVS);
  assign ram_re    = (state_q == S_RD);
  assign ram_we    = (state_q == S_DISPATCH) && (kind_q == KIND_FRAME) && cfg_i.interp &&
                     bv_q && (pcnt_q < CNT_W'(QUEUE_DEPTH));

  ftr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (DIV_W'(cnt_q)),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  ftr_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pcnt_q[QAW-1:0]),
    .wdata_i (tag_q),
    .re_i    (ram_re),
    .raddr_i (idx_q[QAW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q <= KIND_TS_FIXED;
      t_q <= '0; base_q <= '0; st_q <= '0; tag_q <= '0;
      bv_q <= 1'b0; flush_q <= 1'b0;
      fc_q <= '0; ft_q <= '0; ph_q <= 2'd0; nom_q <= '0;
      pcnt_q <= '0; idx_q <= '0; cnt_q <= '0;
      prod_q <= '0;
      ov_q <= 1'b0; ol_q <= 1'b0; od_q <= '0;
      em_tag_q <= '0; em_has_q <= 1'b0; em_last_q <= 1'b0;
      em_st_q <= '0; em_en_q <= '0;
    end else begin
      if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_i.clear) begin
        bv_q <= 1'b0; base_q <= '0; fc_q <= '0; pcnt_q <= '0;
        ft_q <= '0; ph_q <= 2'd0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            kind_q <= cmd_i.kind;
            t_q <= cmd_i.sample_time;
            tag_q <= cmd_i.frame_tag;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (kind_q)
            KIND_FRAME: begin
              fc_q <= fc_q + FC_W'(1);
              if (fc_q == '1) begin
                ft_q <= '0; ph_q <= 2'd0;
              end else begin
                ft_q <= ft_q + ft_step;
                ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
              end
              if (cfg_i.interp && bv_q) begin
                if (ram_we) begin
                  pcnt_q <= pcnt_q + CNT_W'(1);
                end
                state_q <= S_IDLE;
              end else if (bv_q) begin
                em_tag_q <= tag_q; em_has_q <= 1'b1; em_last_q <= 1'b1;
                em_st_q <= base_q + TIME_W'(ft_q);
                em_en_q <= base_q + TIME_W'(ft_q) + TIME_W'(ft_step);
                state_q <= S_EMIT;
              end else begin
                em_tag_q <= tag_q; em_has_q <= 1'b0; em_last_q <= 1'b1;
                em_st_q <= '0; em_en_q <= '0;
                state_q <= S_EMIT;
              end
            end
            KIND_TS_FIXED: begin
              if (!bv_q) begin
                base_q <= t_q; bv_q <= 1'b1; fc_q <= '0;
                ft_q <= '0; ph_q <= 2'd0;
                state_q <= S_IDLE;
              end else begin
                nom_q <= (TIME_W+1)'(base_q) + (TIME_W+1)'(ft_q);
                state_q <= S_CHK;
              end
            end
            default: begin
              cnt_q <= pcnt_q;
              idx_q <= '0;
              st_q <= base_q;
              flush_q <= is_flush;
              if (pcnt_q == '0) begin
                base_q <= t_q; bv_q <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                state_q <= S_RD;
              end
            end
          endcase
        end
        S_CHK: begin
          if (diff > (TIME_W+1)'(cfg_i.max_jitter)) begin
            base_q <= t_q; fc_q <= '0; ft_q <= '0; ph_q <= 2'd0;
          end
          state_q <= S_IDLE;
        end
        S_MUL: begin
          prod_q <= prod_i[PROD_W-1:0];
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            em_tag_q <= ram_rdata; em_has_q <= 1'b1;
            em_last_q <= (idx1 == cnt_q);
            em_st_q <= st_q; em_en_q <= sum[TIME_W-1:0];
            st_q <= sum[TIME_W-1:0];
            state_q <= S_EMIT;
          end
        end
        S_RD: begin
          state_q <= S_RDW;
        end
        S_RDW: begin
          if (flush_q) begin
            em_tag_q <= ram_rdata; em_has_q <= 1'b0;
            em_last_q <= (idx1 == cnt_q);
            em_st_q <= '0; em_en_q <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            ov_q <= 1'b1;
            ol_q <= em_last_q;
            od_q <= {3'b000, em_en_q, em_st_q, em_has_q, em_tag_q};
            if (kind_q == KIND_TS_INTERP) begin
              if (em_last_q) begin
                pcnt_q <= '0; base_q <= t_q; bv_q <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                idx_q <= idx1;
                state_q <= S_RD;
              end
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tlast_o  = ol_q;

  `FTR_ASSERT_NEVER(a_pcnt_bound, pcnt_q > CNT_W'(QUEUE_DEPTH), "pending count overflow")
  `FTR_ASSERT(a_div_start_idle, div_start |-> !div_busy, "divider started while busy")
  `FTR_ASSERT(a_pop_valid, cmd_pop_o |-> cmd_valid_i, "pop from empty command queue")
  `FTR_ASSERT(a_ram_we_room, ram_we |-> (pcnt_q < CNT_W'(QUEUE_DEPTH)), "write to full queue")
endmodule

>>> hdl/frame_timestamp_regenerator_core.sv
// Sequence: a frame released at once passes IDLE, DISPATCH and EMIT into the output register;
// a queued frame frees the back end from DISPATCH and a fixed-mode timestamp after CHK.
// Each interpolated release passes RD, RDW, MUL, DIVS, DIVW (64-step serial divider) and EMIT;
// a flushed queue releases each item through RD, RDW and EMIT.
// Throughput: one item at a time in the back end; an output stall holds it in EMIT.
// Reset (rst_ni low, asynchronous) clears all control state; the tag RAM is not cleared.
module frame_timestamp_regenerator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: sample_time [61:0], frame_tag [77:62], zero fill [79:78]
  input  logic [79:0]               s_axis_tdata_i,
  // tuser: cmd (0 timestamp, 1 decoded frame)
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // tdata: out_tag [15:0], has_time [16], start_time [78:17], end_time [140:79], zero fill
  output logic [143:0]              m_axis_tdata_o,
  output logic                      m_axis_tlast_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [ftr_pkg::CFG_W-1:0] cfg_wdata_i
);
  import ftr_pkg::*;

  // The front holds the registers and classifies each item; the back owns timing state.
  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  ftr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cfg_o           (cfg),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Results leave through a registered output stage inside the back end.
  ftr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );
endmodule
